FILE: rtl/ipt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipt_pkg;

  // Sizes of the node store and of the request fields.
  localparam int NODE_COUNT = 4096;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int FREE_BITS  = $clog2(NODE_COUNT + 1);
  localparam int ZONE_BITS  = 16;
  localparam int ADDR_BITS  = 32;
  localparam int LEN_BITS   = 6;
  localparam int OUT_ZONE_BITS = 16;

  // One trie node: the two child links and the zone tag.
  typedef struct packed {
    logic [NODE_BITS-1:0] link0;
    logic [NODE_BITS-1:0] link1;
    logic [ZONE_BITS-1:0] zone;
  } node_t;

  localparam int NODE_WIDTH = $bits(node_t);

  // Request function codes.
  typedef enum logic [0:0] {
    FUNC_ADD    = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  // Result status codes.
  typedef enum logic [0:0] {
    STATUS_DONE = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_GROW,
    ST_TAG,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/ipv4_prefix_trie.sv
`timescale 1ns / 1ps
`default_nettype none

// Longest-prefix-match binary trie over IPv4 addresses, walked from the most
// significant bit, with its nodes held in one single-port-read, single-port-write
// node memory and fresh nodes taken from a bump allocator. One request is worked
// on at a time. A lookup reads one node per cycle down the path, so it takes
// (matched depth + 1) node reads, at most 33. An add reads the existing path in
// the same way, then writes once per new node and once for the tag. The reads
// and the new nodes together cover at most 33 trie levels. A finished result
// waits in an output register, so the next request can be accepted while it is
// still stalled. The root entry reads as cleared until it is first written, so
// no clearing pass is needed after reset.
module ipv4_prefix_trie (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           func_i,
  input  wire logic [ipt_pkg::ADDR_BITS-1:0]  ip_address_i,
  input  wire logic [ipt_pkg::LEN_BITS-1:0]   prefix_length_i,
  input  wire logic [15:0]                    zone_tag_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [ipt_pkg::OUT_ZONE_BITS-1:0]   found_zone_o,
  output logic                                status_o
);

  import ipt_pkg::*;

  state_e                state_q, state_d;
  func_e                 func_q, func_d;
  logic [ADDR_BITS-1:0]  addr_q, addr_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [ZONE_BITS-1:0]  tag_q, tag_d;
  logic [LEN_BITS-1:0]   level_q, level_d;
  logic [NODE_BITS-1:0]  node_q, node_d;
  node_t                 hold_q, hold_d;
  logic [ZONE_BITS-1:0]  best_q, best_d;
  logic [FREE_BITS-1:0]  next_free_q, next_free_d;
  logic                  root_wr_q;
  logic                  res_status_q, res_status_d;
  logic [ZONE_BITS-1:0]  res_zone_q, res_zone_d;
  logic                  out_valid_q;
  logic [OUT_ZONE_BITS-1:0] found_zone_q;
  logic                  status_q;

  logic                  rd_en;
  logic [NODE_BITS-1:0]  rd_addr;
  logic [NODE_WIDTH-1:0] rd_data;
  logic                  wr_en;
  logic [NODE_BITS-1:0]  wr_addr;
  node_t                 wr_data;

  node_t                 cur;
  logic                  bit_now;
  logic [NODE_BITS-1:0]  child;
  logic [LEN_BITS-1:0]   need;
  logic [FREE_BITS-1:0]  avail;
  logic                  in_accept;
  logic                  out_free;

  // Node memory.
  ipt_node_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NODE_WIDTH)
  ) u_node_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The node just read; the root reads as cleared until first written.
  always_comb begin
    if ((node_q == '0) && !root_wr_q) begin
      cur = '0;
    end else begin
      cur = node_t'(rd_data);
    end
  end

  assign bit_now = addr_q[ADDR_BITS-1];
  assign child   = bit_now ? cur.link1 : cur.link0;
  assign need    = len_q - level_q;
  assign avail   = FREE_BITS'(NODE_COUNT) - next_free_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state, memory accesses and working registers.
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    addr_d       = addr_q;
    len_d        = len_q;
    tag_d        = tag_q;
    level_d      = level_q;
    node_d       = node_q;
    hold_d       = hold_q;
    best_d       = best_q;
    next_free_d  = next_free_q;
    res_status_d = res_status_q;
    res_zone_d   = res_zone_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = node_q;
    wr_data      = hold_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          func_d  = func_e'(func_i);
          addr_d  = ip_address_i;
          if (prefix_length_i > LEN_BITS'(ADDR_BITS)) begin
            len_d = LEN_BITS'(ADDR_BITS);
          end else begin
            len_d = prefix_length_i;
          end
          tag_d   = ZONE_BITS'(zone_tag_i);
          level_d = '0;
          node_d  = '0;
          best_d  = '0;
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = ST_WALK;
        end
      end

      ST_WALK: begin
        if (func_q == FUNC_LOOKUP) begin
          if (cur.zone != '0) begin
            best_d = cur.zone;
          end
          if ((level_q == LEN_BITS'(ADDR_BITS)) || (child == '0)) begin
            res_zone_d   = best_d;
            res_status_d = STATUS_DONE;
            state_d      = ST_FINISH;
          end else begin
            node_d  = child;
            level_d = level_q + 1'b1;
            addr_d  = addr_q << 1;
            rd_en   = 1'b1;
            rd_addr = child;
          end
        end else begin
          if ((level_q < len_q) && (child != '0)) begin
            node_d  = child;
            level_d = level_q + 1'b1;
            addr_d  = addr_q << 1;
            rd_en   = 1'b1;
            rd_addr = child;
          end else begin
            hold_d     = cur;
            res_zone_d = '0;
            if (FREE_BITS'(need) > avail) begin
              res_status_d = STATUS_FULL;
              state_d      = ST_FINISH;
            end else if (level_q == len_q) begin
              state_d = ST_TAG;
            end else begin
              state_d = ST_GROW;
            end
          end
        end
      end

      // Link a fresh node under the current one and step down to it.
      ST_GROW: begin
        wr_en   = 1'b1;
        wr_addr = node_q;
        wr_data = hold_q;
        if (bit_now) begin
          wr_data.link1 = NODE_BITS'(next_free_q);
        end else begin
          wr_data.link0 = NODE_BITS'(next_free_q);
        end
        node_d      = NODE_BITS'(next_free_q);
        next_free_d = next_free_q + 1'b1;
        hold_d      = '0;
        level_d     = level_q + 1'b1;
        addr_d      = addr_q << 1;
        if ((level_q + 1'b1) == len_q) begin
          state_d = ST_TAG;
        end
      end

      // Write the zone into the final node of the prefix.
      ST_TAG: begin
        wr_en        = 1'b1;
        wr_addr      = node_q;
        wr_data      = hold_q;
        wr_data.zone = tag_q;
        res_status_d = STATUS_DONE;
        state_d      = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_free_q <= FREE_BITS'(1);
      root_wr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      if (wr_en && (wr_addr == '0)) begin
        root_wr_q <= 1'b1;
      end
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    addr_q       <= addr_d;
    len_q        <= len_d;
    tag_q        <= tag_d;
    level_q      <= level_d;
    node_q       <= node_d;
    hold_q       <= hold_d;
    best_q       <= best_d;
    res_status_q <= res_status_d;
    res_zone_q   <= res_zone_d;
    if ((state_q == ST_FINISH) && out_free) begin
      found_zone_q <= OUT_ZONE_BITS'(res_zone_q);
      status_q     <= res_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_zone_o = found_zone_q;
  assign status_o     = status_q;

  // The allocator never passes the end of the node store.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= FREE_BITS'(NODE_COUNT))
    else $error("node allocator ran past the store");

  // Memory writes happen only while growing the path or tagging.
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((state_q == ST_GROW) || (state_q == ST_TAG)))
    else $error("node write outside an add");

  // Each grow step takes exactly one fresh node.
  a_grow_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GROW) |=> (next_free_q == $past(next_free_q) + 1'b1))
    else $error("grow step did not allocate one node");

  // A refused add leaves the allocator untouched.
  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && (res_status_q == STATUS_FULL))
      |-> (next_free_q == $past(next_free_q)))
    else $error("refused add changed the allocator");

  // The walk never goes deeper than the address.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (level_q <= LEN_BITS'(ADDR_BITS)))
    else $error("walk went past the last address bit");

endmodule

`default_nettype wire

FILE: rtl/ipt_node_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ipt_node_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 40
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ipt_pkg::*;

  // Result fields as one record, so the answers still due can sit in one queue.
  typedef struct packed {
    logic [OUT_ZONE_BITS-1:0] found_zone;
    status_e                  status;
  } trie_answer_t;

  // One row of the directed table. Where known is set, the answer is given in the row.
  typedef struct packed {
    func_e                    func;
    logic [ADDR_BITS-1:0]     addr;
    logic [LEN_BITS-1:0]      len;
    logic [15:0]              tag;
    bit                       known;
    logic [OUT_ZONE_BITS-1:0] want_zone;
    status_e                  want_status;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 70;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 req_valid = 1'b0;
  func_e                req_func = FUNC_ADD;
  logic [ADDR_BITS-1:0] req_addr = '0;
  logic [LEN_BITS-1:0]  req_len = '0;
  logic [15:0]          req_tag = '0;
  logic                 resp_stall = 1'b0;
  wire logic            in_stall_o;
  wire logic            out_valid_o;
  wire logic [OUT_ZONE_BITS-1:0] found_zone_o;
  wire logic            status_o;

  // Private copy of the trie used for prediction.
  logic [NODE_BITS-1:0] trie_link0 [NODE_COUNT];
  logic [NODE_BITS-1:0] trie_link1 [NODE_COUNT];
  logic [ZONE_BITS-1:0] trie_zone  [NODE_COUNT];
  int                   trie_next_free;

  trie_answer_t         answers_due[$];
  logic [ADDR_BITS-1:0] route_pool [16];
  int  fail_count = 0;
  int  add_count = 0;
  int  lookup_count = 0;
  int  full_count = 0;
  int  hit_count = 0;
  bit  steady = 1'b0;
  bit  hold_pending = 1'b0;
  int  hold_left = 0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{FUNC_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b1, 16'h0000, STATUS_DONE},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 1'b1, 16'h0000, STATUS_DONE},
    '{FUNC_ADD,    32'h0000_0000, 6'd0,  16'hFFFF, 1'b1, 16'h0000, STATUS_DONE},
    '{FUNC_LOOKUP, 32'h1234_5678, 6'd0,  16'h0000, 1'b1, 16'hFFFF, STATUS_DONE},
    '{FUNC_ADD,    32'h8000_0000, 6'd1,  16'h0001, 1'b1, 16'h0000, STATUS_DONE},
    '{FUNC_LOOKUP, 32'hC000_0000, 6'd0,  16'h0000, 1'b1, 16'h0001, STATUS_DONE},
    '{FUNC_LOOKUP, 32'h4000_0000, 6'd0,  16'h0000, 1'b1, 16'hFFFF, STATUS_DONE},
    '{FUNC_ADD,    32'hFFFF_FFFF, 6'd32, 16'h1234, 1'b1, 16'h0000, STATUS_DONE},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1, 16'h1234, STATUS_DONE},
    '{FUNC_LOOKUP, 32'hFFFF_FFFE, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_ADD,    32'hFFFF_FFFF, 6'd63, 16'hABCD, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_ADD,    32'h8000_0000, 6'd1,  16'h0000, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_LOOKUP, 32'h8000_0001, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_ADD,    32'h0000_0000, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_ADD,    32'h0A00_0000, 6'd8,  16'h0010, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_ADD,    32'h0A0B_0000, 6'd16, 16'h0020, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_LOOKUP, 32'h0A0B_0C0D, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_LOOKUP, 32'h0A0C_0000, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_ADD,    32'h0000_0000, 6'd32, 16'h5555, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_DONE},
    '{FUNC_ADD,    32'h5555_5555, 6'd40, 16'hAAAA, 1'b0, 16'h0000, STATUS_DONE}
  };

  ipv4_prefix_trie i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (req_valid),
    .in_stall_o      (in_stall_o),
    .func_i          (req_func),
    .ip_address_i    (req_addr),
    .prefix_length_i (req_len),
    .zone_tag_i      (req_tag),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (resp_stall),
    .found_zone_o    (found_zone_o),
    .status_o        (status_o)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Reset is held at the start and never again.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard limit on the length of the run.
  initial begin
    #15ms;
    $display("Timed out with %0d results still outstanding.", answers_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // Walks the private trie for one request, updating it for an add, and returns the answer.
  function automatic trie_answer_t walk_trie(func_e f, logic [ADDR_BITS-1:0] addr,
                                             logic [LEN_BITS-1:0] len_in,
                                             logic [15:0] tag);
    trie_answer_t         ans;
    int                   len;
    int                   level;
    int                   node;
    int                   kid;
    int                   need;
    logic [ZONE_BITS-1:0] best;
    ans.found_zone = '0;
    ans.status     = STATUS_DONE;
    len   = (len_in > ADDR_BITS) ? ADDR_BITS : int'(len_in);
    node  = 0;
    level = 0;
    best  = '0;
    if (f == FUNC_ADD) begin
      // Follow the existing path as far as it goes.
      while (level < len) begin
        kid = addr[ADDR_BITS-1-level] ? trie_link1[node] : trie_link0[node];
        if (kid == 0) break;
        node = kid;
        level++;
      end
      need = len - level;
      if (trie_next_free > NODE_COUNT || need > NODE_COUNT - trie_next_free) begin
        ans.status = STATUS_FULL;
      end else begin
        // Grow the missing part of the path from the bump allocator.
        while (level < len) begin
          kid = trie_next_free;
          trie_next_free++;
          trie_link0[kid] = '0;
          trie_link1[kid] = '0;
          trie_zone[kid]  = '0;
          if (addr[ADDR_BITS-1-level]) trie_link1[node] = NODE_BITS'(kid);
          else trie_link0[node] = NODE_BITS'(kid);
          node = kid;
          level++;
        end
        trie_zone[node] = ZONE_BITS'(tag);
      end
    end else begin
      // Keep the deepest nonzero tag along the path, depth 32 included.
      while (1) begin
        if (trie_zone[node] != '0) best = trie_zone[node];
        if (level >= ADDR_BITS) break;
        kid = addr[ADDR_BITS-1-level] ? trie_link1[node] : trie_link0[node];
        if (kid == 0 || kid >= NODE_COUNT) break;
        node = kid;
        level++;
      end
      ans.found_zone = OUT_ZONE_BITS'(best);
    end
    return ans;
  endfunction

  // Counts a mismatch and prints a line for each of the first 100.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 100) begin
      $display("Mismatch at %0t: %s got %h, expected %h", $realtime, what, got, want);
    end
  endtask

  // Drives one request and holds it until it is accepted, then records its answer.
  task automatic offer_request(func_e f, logic [ADDR_BITS-1:0] a, logic [LEN_BITS-1:0] l,
                               logic [15:0] t, bit known, trie_answer_t known_ans);
    trie_answer_t ans;
    req_valid <= 1'b1;
    req_func  <= f;
    req_addr  <= a;
    req_len   <= l;
    req_tag   <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ans = walk_trie(f, a, l, t);
    if (known) ans = known_ans;
    if (f == FUNC_ADD) begin
      add_count++;
      if (ans.status == STATUS_FULL) full_count++;
    end else begin
      lookup_count++;
      if (ans.found_zone != '0) hit_count++;
    end
    answers_due.push_back(ans);
  endtask

  // Leaves the request side idle now and then, unless a steady stretch is running.
  task automatic maybe_idle();
    int gap;
    if (!steady && $urandom_range(99) < 13) begin
      gap = $urandom_range(4, 1);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lowers valid and waits until every outstanding result has arrived.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  // A request around one of a few base routes, so that paths share nodes and lookups hit.
  task automatic offer_pool_request();
    func_e                f;
    logic [ADDR_BITS-1:0] a;
    logic [LEN_BITS-1:0]  l;
    logic [15:0]          t;
    f = ($urandom_range(1) == 1) ? FUNC_LOOKUP : FUNC_ADD;
    a = route_pool[$urandom_range(15)] ^ ($urandom & (32'hFFFF_FFFF >> $urandom_range(32)));
    if ($urandom_range(99) < 10) l = LEN_BITS'($urandom_range(63, 33));
    else l = LEN_BITS'($urandom_range(32));
    t = ($urandom_range(99) < 8) ? 16'h0000 : 16'($urandom);
    maybe_idle();
    offer_request(f, a, l, t, 1'b0, '0);
  endtask

  // Request side: directed table, then three random phases.
  initial begin
    trie_answer_t         known_ans;
    logic [ADDR_BITS-1:0] a;
    for (int i = 0; i < NODE_COUNT; i++) begin
      trie_link0[i] = '0;
      trie_link1[i] = '0;
      trie_zone[i]  = '0;
    end
    trie_next_free = 1;
    for (int i = 0; i < 16; i++) route_pool[i] = $urandom;

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    // Directed rows: extremes, default route, depth 32, long prefix and tag clearing.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      known_ans.found_zone = directed_rows[i].want_zone;
      known_ans.status     = directed_rows[i].want_status;
      maybe_idle();
      offer_request(directed_rows[i].func, directed_rows[i].addr, directed_rows[i].len,
                    directed_rows[i].tag, directed_rows[i].known, known_ans);
    end
    drain_results();

    // Routes clustered around the base pool, with one long output hold-off.
    for (int i = 0; i < 550; i++) begin
      if (i == 100) hold_pending = 1'b1;
      steady = (i >= 200 && i < 330);
      offer_pool_request();
    end
    steady = 1'b0;
    drain_results();

    // Mostly long prefixes at scattered addresses, which exhausts the node store.
    for (int i = 0; i < 300; i++) begin
      a = $urandom;
      maybe_idle();
      if ($urandom_range(99) < 70) begin
        offer_request(FUNC_ADD, a, LEN_BITS'($urandom_range(32, 24)), 16'($urandom),
                      1'b0, '0);
      end else begin
        offer_request(FUNC_LOOKUP, a, LEN_BITS'($urandom), 16'($urandom), 1'b0, '0);
      end
    end
    drain_results();

    // With the store full, adds on existing paths still succeed and others are refused.
    for (int i = 0; i < 250; i++) offer_pool_request();
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d adds (%0d refused for a full node store) and %0d lookups (%0d hit).",
             add_count, full_count, lookup_count, hit_count);
    $display("Node store use at the end: %0d of %0d nodes.", trie_next_free, NODE_COUNT);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches.", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: checks each accepted result and drives the stall.
  initial begin
    trie_answer_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !resp_stall) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected result, found_zone", 32'(found_zone_o), 32'h0);
        end else begin
          want = answers_due.pop_front();
          if (found_zone_o !== want.found_zone) begin
            report_mismatch("found_zone", 32'(found_zone_o), 32'(want.found_zone));
          end
          if (status_o !== want.status) begin
            report_mismatch("status", 32'(status_o), 32'(want.status));
          end
        end
      end
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        resp_stall <= 1'b1;
        hold_left--;
      end else if (steady) begin
        resp_stall <= 1'b0;
      end else begin
        resp_stall <= ($urandom_range(99) < 13);
      end
    end
  end

endmodule

FILE: ipv4_prefix_trie.f
rtl/ipt_pkg.sv
rtl/ipt_node_ram.sv
rtl/ipv4_prefix_trie.sv
tb/sv/testbench.sv
